@@ hw/rtl/lrb_pkg.sv @@
// Shared types and codes of the local alignment row-best core.
`default_nettype none

package lrb_pkg;

    // Width of the query length register.
    localparam int QLEN_W = 9;
    // Number of query positions a load item can address.
    localparam int POS_RANGE = 256;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_QUERY_LENGTH     = 3'd0;
    localparam logic [2:0] REG_MATCH_SCORE      = 3'd1;
    localparam logic [2:0] REG_MISMATCH_SCORE   = 3'd2;
    localparam logic [2:0] REG_GAP_OPEN_SCORE   = 3'd3;
    localparam logic [2:0] REG_GAP_EXTEND_SCORE = 3'd4;

    typedef enum logic [0:0] {
        CMD_LOAD  = 1'b0,
        CMD_ALIGN = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [QLEN_W-1:0]  query_length;
        logic signed [7:0]  match_score;
        logic signed [7:0]  mismatch_score;
        logic signed [7:0]  gap_open_score;
        logic signed [7:0]  gap_extend_score;
    } t_cfg;

    // Control part of an item traveling down the cell chain.
    typedef struct packed {
        logic       valid;
        t_cmd       cmd;
        logic       first;
        logic [7:0] symbol;
        logic [7:0] pos;
        logic       sat;
    } t_tok;

endpackage

`default_nettype wire

@@ hw/rtl/lrb_cell.sv @@
// One query column of the alignment chain: symbol, score and vertical gap state.
`default_nettype none

module lrb_cell #(
    parameter int SCORE_BITS = 16,
    parameter int INDEX      = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_adv,
    input  wire lrb_pkg::t_cfg         i_cfg,
    input  wire lrb_pkg::t_tok         i_tok,
    input  wire logic [SCORE_BITS-1:0] i_left,
    input  wire logic [SCORE_BITS-1:0] i_horiz,
    input  wire logic [SCORE_BITS-1:0] i_diag,
    input  wire logic [SCORE_BITS-1:0] i_best,
    output lrb_pkg::t_tok              o_tok,
    output logic [SCORE_BITS-1:0]      o_left,
    output logic [SCORE_BITS-1:0]      o_horiz,
    output logic [SCORE_BITS-1:0]      o_diag,
    output logic [SCORE_BITS-1:0]      o_best
);
    import lrb_pkg::*;

    localparam int SW = SCORE_BITS + 2;
    localparam bit REACH    = INDEX < (1 << QLEN_W);
    localparam int LEN_LIM  = REACH ? INDEX : 0;
    localparam bit LOADABLE = INDEX < POS_RANGE;
    localparam int POS_LIM  = LOADABLE ? INDEX : 0;

    logic [7:0]            r_sym;
    logic [SCORE_BITS-1:0] r_h;
    logic [SCORE_BITS-1:0] r_vg;
    t_tok                  r_tok;
    t_tok                  n_tok;
    logic [SCORE_BITS-1:0] r_left;
    logic [SCORE_BITS-1:0] r_horiz;
    logic [SCORE_BITS-1:0] r_diag;
    logic [SCORE_BITS-1:0] r_best;

    logic                  w_active;
    logic                  w_align;
    logic                  w_load;
    logic signed [7:0]     w_sub;
    logic [SCORE_BITS-1:0] w_h_old;
    logic [SCORE_BITS-1:0] w_vg_old;
    logic signed [SW-1:0]  w_diag_sum;
    logic signed [SW-1:0]  w_vopen;
    logic signed [SW-1:0]  w_vext;
    logic signed [SW-1:0]  w_hopen;
    logic signed [SW-1:0]  w_hext;
    logic signed [SW-1:0]  w_vmax;
    logic signed [SW-1:0]  w_hmax;
    logic signed [SW-1:0]  w_cmax;
    logic signed [SW-1:0]  w_vgap_ext;
    logic signed [SW-1:0]  w_hgap_ext;
    logic                  w_v_over;
    logic                  w_h_over;
    logic                  w_c_over;
    logic [SCORE_BITS-1:0] w_vgap;
    logic [SCORE_BITS-1:0] w_hgap;
    logic [SCORE_BITS-1:0] w_cell;
    logic [SCORE_BITS-1:0] w_best;

    function automatic logic signed [SW-1:0] ext_u(input logic [SCORE_BITS-1:0] v);
        return $signed({2'b00, v});
    endfunction

    function automatic logic signed [SW-1:0] ext_s(input logic signed [7:0] v);
        return $signed({{(SW-8){v[7]}}, v});
    endfunction

    always_comb begin
        w_active = REACH && (QLEN_W'(LEN_LIM) < i_cfg.query_length);
        w_align  = i_tok.valid && (i_tok.cmd == CMD_ALIGN);
        w_load   = i_tok.valid && (i_tok.cmd == CMD_LOAD) && LOADABLE
                   && (i_tok.pos == 8'(POS_LIM));
        w_sub    = (i_tok.symbol == r_sym) ? i_cfg.match_score : i_cfg.mismatch_score;
        // A first database symbol sees a cleared row and cleared gaps.
        w_h_old  = i_tok.first ? '0 : r_h;
        w_vg_old = i_tok.first ? '0 : r_vg;

        w_diag_sum = ext_u(i_diag) + ext_s(w_sub);
        w_vopen    = ext_u(w_h_old) + ext_s(i_cfg.gap_open_score);
        w_vext     = ext_u(w_vg_old) + ext_s(i_cfg.gap_extend_score);
        w_hopen    = ext_u(i_left) + ext_s(i_cfg.gap_open_score);
        w_hext     = ext_u(i_horiz) + ext_s(i_cfg.gap_extend_score);

        w_vmax = (w_vopen > w_vext) ? w_vopen : w_vext;
        if (w_vmax[SW-1]) begin
            w_vmax = '0;
        end
        w_hmax = (w_hopen > w_hext) ? w_hopen : w_hext;
        if (w_hmax[SW-1]) begin
            w_hmax = '0;
        end
        w_v_over = |w_vmax[SW-2:SCORE_BITS];
        w_h_over = |w_hmax[SW-2:SCORE_BITS];
        w_vgap   = w_v_over ? '1 : w_vmax[SCORE_BITS-1:0];
        w_hgap   = w_h_over ? '1 : w_hmax[SCORE_BITS-1:0];

        // Both gap scores are non-negative, so the cell is never below zero.
        w_vgap_ext = ext_u(w_vgap);
        w_hgap_ext = ext_u(w_hgap);
        w_cmax = (w_vgap_ext > w_hgap_ext) ? w_vgap_ext : w_hgap_ext;
        if (w_diag_sum > w_cmax) begin
            w_cmax = w_diag_sum;
        end
        w_c_over = |w_cmax[SW-2:SCORE_BITS];
        w_cell   = w_c_over ? '1 : w_cmax[SCORE_BITS-1:0];
        w_best   = (w_cell > i_best) ? w_cell : i_best;

        n_tok = i_tok;
        if (w_align && w_active) begin
            n_tok.sat = i_tok.sat | w_v_over | w_h_over | w_c_over;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h  <= '0;
            r_vg <= '0;
        end else if (i_adv && w_align) begin
            if (w_active) begin
                r_h  <= w_cell;
                r_vg <= w_vgap;
            end else if (i_tok.first) begin
                r_h  <= '0;
                r_vg <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && w_load) begin
            r_sym <= i_tok.symbol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (w_align && w_active) begin
                r_left  <= w_cell;
                r_horiz <= w_hgap;
                r_diag  <= w_h_old;
                r_best  <= w_best;
            end else begin
                r_left  <= i_left;
                r_horiz <= i_horiz;
                r_diag  <= i_diag;
                r_best  <= i_best;
            end
        end
    end

    assign o_tok   = r_tok;
    assign o_left  = r_left;
    assign o_horiz = r_horiz;
    assign o_diag  = r_diag;
    assign o_best  = r_best;

`ifndef SYNTH
    a_best_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && w_align) |=> (r_best >= $past(i_best)))
        else $error("row best dropped while passing a cell");

    a_sat_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && w_align && i_tok.sat) |=> r_tok.sat)
        else $error("saturation flag lost in the chain");

    a_best_covers_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && w_align && w_active) |=> (r_best >= r_left))
        else $error("row best below the cell just computed");

    a_idle_cell_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && w_align && i_tok.first && !w_active) |=> (r_h == '0 && r_vg == '0))
        else $error("unused column kept scores across a first database symbol");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/local_alignment_row_best_core.sv @@
// Top level of the local alignment row-best core: configuration and cell chain.
// Usage:
// Items enter on the s_axis channel. A load item (tuser = 0) writes a query
// symbol at query_pos; an align item (tuser = 1) scores one database symbol
// against the query and yields one result on m_axis: the best cell of that
// score-matrix row and a saturation flag. Load items yield no result.
// Each item travels down a chain of MAX_QUERY cells, one cell per cycle while
// the chain advances. The chain is fully pipelined: one item is accepted per
// cycle unless it stalls, and results leave in order.
// The last cell's register is the output register. While it holds a result the
// receiver does not take, the whole chain and s_axis_tready stall; a load item
// in that place never stalls. Reset clears the row and gap scores and sets the
// registers to their defaults; query symbols must be loaded before use.
// Registers must be written through i_cfg_wr_en/i_cfg_index/i_cfg_data while no
// item is in the chain (not enforced by the block); writes take effect at once.
`default_nettype none

module local_alignment_row_best_core #(
    parameter int MAX_QUERY  = 256,
    parameter int SCORE_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] symbol, [15:8] query_pos, [16] first_of_db, [23:17] zero
    input  wire logic [23:0] s_axis_tdata,
    // [0] cmd
    input  wire logic [0:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] row_best, [16] saturated, [23:17] zero
    output logic [23:0]      m_axis_tdata
);
    import lrb_pkg::*;

    t_cfg                  r_cfg;
    t_tok                  w_tok   [0:MAX_QUERY];
    logic [SCORE_BITS-1:0] w_left  [0:MAX_QUERY];
    logic [SCORE_BITS-1:0] w_horiz [0:MAX_QUERY];
    logic [SCORE_BITS-1:0] w_diag  [0:MAX_QUERY];
    logic [SCORE_BITS-1:0] w_best  [0:MAX_QUERY];
    logic                  w_adv;
    logic                  w_out_valid;
    logic                  w_big;
    logic [15:0]           w_best16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.query_length     <= QLEN_W'(1);
            r_cfg.match_score      <= 8'sd2;
            r_cfg.mismatch_score   <= -8'sd1;
            r_cfg.gap_open_score   <= -8'sd3;
            r_cfg.gap_extend_score <= -8'sd1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_QUERY_LENGTH: begin
                    r_cfg.query_length <= i_cfg_data;
                end
                REG_MATCH_SCORE: begin
                    r_cfg.match_score <= $signed(i_cfg_data[7:0]);
                end
                REG_MISMATCH_SCORE: begin
                    r_cfg.mismatch_score <= $signed(i_cfg_data[7:0]);
                end
                REG_GAP_OPEN_SCORE: begin
                    r_cfg.gap_open_score <= $signed(i_cfg_data[7:0]);
                end
                REG_GAP_EXTEND_SCORE: begin
                    r_cfg.gap_extend_score <= $signed(i_cfg_data[7:0]);
                end
                default: begin
                end
            endcase
        end
    end

    assign w_out_valid = w_tok[MAX_QUERY].valid && (w_tok[MAX_QUERY].cmd == CMD_ALIGN);
    assign w_adv       = !(w_out_valid && !m_axis_tready);
    assign s_axis_tready = w_adv;

    always_comb begin
        w_tok[0].valid  = s_axis_tvalid;
        w_tok[0].cmd    = t_cmd'(s_axis_tuser[0]);
        w_tok[0].first  = s_axis_tdata[16];
        w_tok[0].symbol = s_axis_tdata[7:0];
        w_tok[0].pos    = s_axis_tdata[15:8];
        w_tok[0].sat    = 1'b0;
        w_left[0]       = '0;
        w_horiz[0]      = '0;
        w_diag[0]       = '0;
        w_best[0]       = '0;
    end

    for (genvar g = 0; g < MAX_QUERY; g++) begin : g_cell
        lrb_cell #(
            .SCORE_BITS (SCORE_BITS),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_cfg   (r_cfg),
            .i_tok   (w_tok[g]),
            .i_left  (w_left[g]),
            .i_horiz (w_horiz[g]),
            .i_diag  (w_diag[g]),
            .i_best  (w_best[g]),
            .o_tok   (w_tok[g+1]),
            .o_left  (w_left[g+1]),
            .o_horiz (w_horiz[g+1]),
            .o_diag  (w_diag[g+1]),
            .o_best  (w_best[g+1])
        );
    end

    // A row best wider than the result field is reported at its limit.
    if (SCORE_BITS > 16) begin : g_wide
        assign w_big = |w_best[MAX_QUERY][SCORE_BITS-1:16];
    end else begin : g_narrow
        assign w_big = 1'b0;
    end

    assign w_best16      = w_big ? 16'hFFFF : 16'(w_best[MAX_QUERY]);
    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = {7'b0, w_tok[MAX_QUERY].sat | w_big, w_best16};

endmodule

`default_nettype wire
